@@ sv/button_debounce_long_press_assert.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the button debouncer
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BDLP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BDLP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bdlp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_pkg
// shared types and constants of the button debouncer with long-press detection
// ----------------------------------------------------------------------------
package bdlp_pkg;

    // width of the debounce and hold counters (8 to 32)
    localparam int COUNT_WIDTH = 16;
    localparam int TICKS_WIDTH = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > TICKS_WIDTH) ? COUNT_WIDTH : TICKS_WIDTH;

    // configuration register indexes
    localparam logic [1:0] REG_POLARITY   = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE   = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS = 2'd2;

    // button states
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_PRESSED = 2'd1;
    localparam logic [1:0] ST_LONG    = 2'd2;

    localparam int IN_DATA_WIDTH  = 8;
    localparam int OUT_DATA_WIDTH = 8;

    typedef struct packed {
        logic                   pin_polarity;
        logic [TICKS_WIDTH-1:0] debounce_ticks;
        logic [TICKS_WIDTH-1:0] long_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic       is_pressed;
        logic       long_press_event;
        logic       released_event;
        logic       pressed_event;
        logic [1:0] button_state;
    } result_t;

endpackage

@@ sv/bdlp_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_cfg
// configuration register file: polarity, debounce and long-press thresholds
// ----------------------------------------------------------------------------
module bdlp_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_valid,
    input  logic [1:0]                   wr_index,
    input  logic [bdlp_pkg::TICKS_WIDTH-1:0] wr_data,
    output bdlp_pkg::cfg_t               cfg
);

    bdlp_pkg::cfg_t cfg_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pin_polarity     <= 1'b1;
            cfg_reg.debounce_ticks   <= bdlp_pkg::TICKS_WIDTH'(5);
            cfg_reg.long_press_ticks <= bdlp_pkg::TICKS_WIDTH'(100);
        end
        else if (wr_valid)
        begin
            unique case (wr_index)
                bdlp_pkg::REG_POLARITY:   cfg_reg.pin_polarity     <= wr_data[0];
                bdlp_pkg::REG_DEBOUNCE:   cfg_reg.debounce_ticks   <= wr_data;
                bdlp_pkg::REG_LONG_PRESS: cfg_reg.long_press_ticks <= wr_data;
                default:                  ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/bdlp_core.sv @@
`timescale 1ns / 1ps
`include "button_debounce_long_press_assert.svh"
// ----------------------------------------------------------------------------
// bdlp_core
// input register, per-tick state update and result generation
// ----------------------------------------------------------------------------
module bdlp_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  bdlp_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_pin,
    output logic              res_valid,
    input  logic              res_ready,
    output bdlp_pkg::result_t res
);

    localparam logic [bdlp_pkg::COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic                             in_valid_reg;
    logic                             pin_reg;
    logic                             prev_level_reg, prev_level_next;
    logic [1:0]                       state_reg, state_next;
    logic                             deb_active_reg, deb_active_next;
    logic [bdlp_pkg::COUNT_WIDTH-1:0] deb_count_reg, deb_count_next;
    logic [bdlp_pkg::COUNT_WIDTH-1:0] hold_count_reg, hold_count_next;
    logic                             long_done_reg, long_done_next;
    logic                             level, rise, fall;
    logic                             ev_press, ev_release, ev_long;
    logic                             step;

    assign step      = in_valid_reg && res_ready;
    assign in_ready  = !in_valid_reg || res_ready;
    assign res_valid = in_valid_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pin_reg <= in_pin;
        end
    end

    // one tick of the debounce and long-press logic
    always_comb
    begin
        level           = cfg.pin_polarity ? pin_reg : !pin_reg;
        rise            = level && !prev_level_reg;
        fall            = !level && prev_level_reg;
        ev_press        = 1'b0;
        ev_release      = 1'b0;
        ev_long         = 1'b0;
        state_next      = state_reg;
        deb_active_next = deb_active_reg;
        deb_count_next  = deb_count_reg;
        hold_count_next = hold_count_reg;
        long_done_next  = long_done_reg;
        prev_level_next = level;

        // press edge restarts both counts
        if (rise)
        begin
            long_done_next  = 1'b0;
            deb_active_next = 1'b1;
            deb_count_next  = '0;
            hold_count_next = '0;
        end

        // release edge
        if (fall)
        begin
            deb_active_next = 1'b0;
            if (state_reg == bdlp_pkg::ST_PRESSED && !long_done_next)
            begin
                state_next = bdlp_pkg::ST_IDLE;
                ev_release = 1'b1;
            end
            else if (state_reg == bdlp_pkg::ST_LONG)
            begin
                state_next = bdlp_pkg::ST_IDLE;
            end
        end

        // saturating counts and debounce expiry
        if (!rise)
        begin
            if (hold_count_reg != CNT_MAX)
            begin
                hold_count_next = hold_count_reg + 1'b1;
            end
            if (deb_active_next)
            begin
                if (deb_count_reg != CNT_MAX)
                begin
                    deb_count_next = deb_count_reg + 1'b1;
                end
                if (bdlp_pkg::CMP_WIDTH'(deb_count_next)
                    >= bdlp_pkg::CMP_WIDTH'(cfg.debounce_ticks))
                begin
                    deb_active_next = 1'b0;
                    if (state_next == bdlp_pkg::ST_IDLE)
                    begin
                        state_next = bdlp_pkg::ST_PRESSED;
                        ev_press   = 1'b1;
                    end
                end
            end
        end

        // long-press threshold
        if (level && state_next == bdlp_pkg::ST_PRESSED && !long_done_next
            && bdlp_pkg::CMP_WIDTH'(hold_count_next)
               >= bdlp_pkg::CMP_WIDTH'(cfg.long_press_ticks))
        begin
            state_next     = bdlp_pkg::ST_LONG;
            long_done_next = 1'b1;
            ev_long        = 1'b1;
        end
    end

    // button state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            state_reg      <= bdlp_pkg::ST_IDLE;
            deb_active_reg <= 1'b0;
            deb_count_reg  <= '0;
            hold_count_reg <= '0;
            long_done_reg  <= 1'b0;
        end
        else if (step)
        begin
            prev_level_reg <= prev_level_next;
            state_reg      <= state_next;
            deb_active_reg <= deb_active_next;
            deb_count_reg  <= deb_count_next;
            hold_count_reg <= hold_count_next;
            long_done_reg  <= long_done_next;
        end
    end

    assign res.button_state     = state_next;
    assign res.pressed_event    = ev_press;
    assign res.released_event   = ev_release;
    assign res.long_press_event = ev_long;
    assign res.is_pressed       = (state_next != bdlp_pkg::ST_IDLE);

    // checks
    `BDLP_ASSERT_IMP(a_release_to_idle, step && ev_release,
        state_next == bdlp_pkg::ST_IDLE, "release event without return to idle")
    `BDLP_ASSERT_NXT(a_long_marks_done, step && ev_long,
        long_done_reg && state_reg == bdlp_pkg::ST_LONG, "long press not recorded")
    `BDLP_ASSERT_IMP(a_long_state_done, state_reg == bdlp_pkg::ST_LONG,
        long_done_reg, "long-pressed state with long-press mark clear")

endmodule

@@ sv/bdlp_out.sv @@
`timescale 1ns / 1ps
`include "button_debounce_long_press_assert.svh"
// ----------------------------------------------------------------------------
// bdlp_out
// result register with skid stage towards the output stream
// ----------------------------------------------------------------------------
module bdlp_out
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bdlp_pkg::OUT_DATA_WIDTH-1:0] in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bdlp_pkg::OUT_DATA_WIDTH-1:0] out_data
);

    logic                                main_valid_reg;
    logic [bdlp_pkg::OUT_DATA_WIDTH-1:0] main_data_reg;
    logic                                skid_valid_reg;
    logic [bdlp_pkg::OUT_DATA_WIDTH-1:0] skid_data_reg;
    logic                                main_free;
    logic                                in_xfer;

    assign in_ready  = !skid_valid_reg;
    assign in_xfer   = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (main_free)
            begin
                main_valid_reg <= skid_valid_reg || in_xfer;
                skid_valid_reg <= 1'b0;
            end
            else if (in_xfer)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        if (in_xfer && !main_free)
        begin
            skid_data_reg <= in_data;
        end
    end

    // checks
    `BDLP_ASSERT_IMP(a_skid_behind_main, skid_valid_reg, main_valid_reg,
        "skid stage holds a result while result register is empty")
    `BDLP_ASSERT_NXT(a_skid_drains_first, skid_valid_reg && out_ready,
        main_valid_reg && main_data_reg == $past(skid_data_reg),
        "skid result not moved into result register")

endmodule

@@ sv/button_debounce_long_press.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press
// button debouncer with long-press detection, one pin sample per transfer
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata[0] pin_level
//  m_axis    out        tdata[1:0] button_state, [2] pressed_event,
//                       [3] released_event, [4] long_press_event, [5] is_pressed
//  cfg       in         cfg_index, cfg_data (always ready)
//
//  one sample per cycle sustained while m_tready stays high; a result passes through
//  the input register, then the result register with skid stage
//  the state update is a single pass of compare and increment logic
//  rst_n clears state and valid flags and loads the default configuration asynchronously
//  output stalls fill the skid stage, then s_tready drops
// ----------------------------------------------------------------------------
module button_debounce_long_press
(
    input  logic                                clk,
    input  logic                                rst_n,
    // tdata: [0] pin_level
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bdlp_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
    // tdata: [1:0] button_state, [2] pressed_event, [3] released_event,
    //        [4] long_press_event, [5] is_pressed
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bdlp_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [bdlp_pkg::TICKS_WIDTH-1:0]    cfg_data
);

    bdlp_pkg::cfg_t    cfg;
    bdlp_pkg::result_t res;
    logic              res_valid;
    logic              res_ready;
    logic [bdlp_pkg::OUT_DATA_WIDTH-1:0] res_data;

    assign cfg_ready = 1'b1;

    // configuration registers
    bdlp_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // tick logic
    bdlp_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pin    (s_tdata[0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // pack result fields, lowest first
    assign res_data = {2'b00, res};

    // result register and skid stage
    bdlp_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
